// ----- sv/dema_pkg.sv -----
// shared types, widths and register codes of the dual ema pressure detector
package dema_pkg;

  // payload widths
  localparam int SAMPLE_W   = 16;
  localparam int AVG_W      = 24;
  localparam int PRESS_W    = 25;
  localparam int ALPHA_W    = 16;
  localparam int THR_W      = 24;
  localparam int WARM_W     = 16;
  localparam int CNT_OUT_W  = 32;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // default event counter width
  localparam int COUNT_BITS_DEF = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FAST_ALPHA = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_ALPHA = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP     = 8'd3;

  // register reset values
  localparam logic [ALPHA_W-1:0] FAST_ALPHA_RST = 16'd6554;
  localparam logic [ALPHA_W-1:0] SLOW_ALPHA_RST = 16'd655;
  localparam logic [THR_W-1:0]   THRESHOLD_RST  = 24'd838861;
  localparam logic [WARM_W-1:0]  WARMUP_RST     = 16'd10;

  typedef struct packed {
    logic [ALPHA_W-1:0] fast_alpha;
    logic [ALPHA_W-1:0] slow_alpha;
    logic [THR_W-1:0]   threshold;
    logic [WARM_W-1:0]  warmup;
  } cfg_t;

  typedef struct packed {
    logic rise;
    logic fall;
  } flags_t;

endpackage

// ----- sv/dema_cfg_regs.sv -----
// configuration register file of the dual ema pressure detector
module dema_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dema_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [dema_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output dema_pkg::cfg_t                    cfg_o
);

  dema_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        dema_pkg::REG_FAST_ALPHA: cfg_d.fast_alpha = cfg_data_i[dema_pkg::ALPHA_W-1:0];
        dema_pkg::REG_SLOW_ALPHA: cfg_d.slow_alpha = cfg_data_i[dema_pkg::ALPHA_W-1:0];
        dema_pkg::REG_THRESHOLD:  cfg_d.threshold  = cfg_data_i[dema_pkg::THR_W-1:0];
        dema_pkg::REG_WARMUP:     cfg_d.warmup     = cfg_data_i[dema_pkg::WARM_W-1:0];
        default: ; // unknown index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fast_alpha <= dema_pkg::FAST_ALPHA_RST;
      cfg_q.slow_alpha <= dema_pkg::SLOW_ALPHA_RST;
      cfg_q.threshold  <= dema_pkg::THRESHOLD_RST;
      cfg_q.warmup     <= dema_pkg::WARMUP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/dema_ema_step.sv -----
// one ema update step: avg + floor(alpha * (x - avg) / 2^16), clamped to q1.23
module dema_ema_step (
  input  logic signed [dema_pkg::AVG_W-1:0]   avg_i,
  input  logic signed [dema_pkg::AVG_W-1:0]   x_i,
  input  logic        [dema_pkg::ALPHA_W-1:0] alpha_i,
  output logic signed [dema_pkg::AVG_W-1:0]   avg_o
);

  localparam int DIFF_W = dema_pkg::AVG_W + 1;
  localparam int PROD_W = DIFF_W + dema_pkg::ALPHA_W + 1;
  localparam int INC_W  = dema_pkg::AVG_W + 2;
  localparam int SUM_W  = dema_pkg::AVG_W + 3;

  localparam logic signed [SUM_W-1:0] AVG_MAX = SUM_W'((1 << (dema_pkg::AVG_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] AVG_MIN = -SUM_W'(1 << (dema_pkg::AVG_W - 1));

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [SUM_W-1:0]  sum;

  assign diff    = DIFF_W'(x_i) - DIFF_W'(avg_i);
  assign prod    = $signed({1'b0, alpha_i}) * diff;
  // arithmetic shift floors toward minus infinity
  assign prod_sh = prod >>> dema_pkg::ALPHA_W;
  assign sum     = SUM_W'(avg_i) + SUM_W'($signed(prod_sh[INC_W-1:0]));

  always_comb begin
    if (sum > AVG_MAX) begin
      avg_o = AVG_MAX[dema_pkg::AVG_W-1:0];
    end else if (sum < AVG_MIN) begin
      avg_o = AVG_MIN[dema_pkg::AVG_W-1:0];
    end else begin
      avg_o = sum[dema_pkg::AVG_W-1:0];
    end
  end

endmodule

// ----- sv/dema_event.sv -----
// threshold crossing detection, warmup gate and saturating event counters
module dema_event #(
  parameter int COUNT_BITS = dema_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  logic signed [dema_pkg::PRESS_W-1:0] press_i,
  input  dema_pkg::cfg_t                      cfg_i,
  output dema_pkg::flags_t                    flags_o,
  output logic        [COUNT_BITS-1:0]        rise_cnt_o,
  output logic        [COUNT_BITS-1:0]        fall_cnt_o,
  output logic        [COUNT_BITS-1:0]        seen_cnt_o
);

  localparam int CMP_W = (COUNT_BITS > dema_pkg::WARM_W) ? COUNT_BITS : dema_pkg::WARM_W;
  localparam int THX_W = dema_pkg::PRESS_W + 1;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    sat_inc = (&c) ? c : c + COUNT_BITS'(1);
  endfunction

  logic                  prev_above_q, prev_above_d;
  logic                  prev_below_q, prev_below_d;
  logic [COUNT_BITS-1:0] rise_q, rise_d;
  logic [COUNT_BITS-1:0] fall_q, fall_d;
  logic [COUNT_BITS-1:0] seen_q, seen_d;

  logic signed [THX_W-1:0] press_x;
  logic signed [THX_W-1:0] thr_x;
  logic                    above;
  logic                    below;
  logic                    armed;

  assign press_x = THX_W'(press_i);
  assign thr_x   = $signed({2'b00, cfg_i.threshold});
  assign above   = press_x > thr_x;
  assign below   = press_x < -thr_x;
  // evaluation starts once earlier samples plus this one reach warmup
  assign armed   = (cfg_i.warmup == '0) ||
                   (CMP_W'(seen_q) >= CMP_W'(cfg_i.warmup) - CMP_W'(1));

  always_comb begin
    prev_above_d = prev_above_q;
    prev_below_d = prev_below_q;
    rise_d       = rise_q;
    fall_d       = fall_q;
    flags_o      = '0;
    if (armed) begin
      flags_o.rise = above && !prev_above_q;
      flags_o.fall = below && !prev_below_q;
      prev_above_d = above;
      prev_below_d = below;
      if (flags_o.rise) begin
        rise_d = sat_inc(rise_q);
      end
      if (flags_o.fall) begin
        fall_d = sat_inc(fall_q);
      end
    end
    seen_d = sat_inc(seen_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_above_q <= 1'b0;
      prev_below_q <= 1'b0;
      rise_q       <= '0;
      fall_q       <= '0;
      seen_q       <= '0;
    end else if (step_i) begin
      prev_above_q <= prev_above_d;
      prev_below_q <= prev_below_d;
      rise_q       <= rise_d;
      fall_q       <= fall_d;
      seen_q       <= seen_d;
    end
  end

  assign rise_cnt_o = rise_d;
  assign fall_cnt_o = fall_d;
  assign seen_cnt_o = seen_d;

endmodule

// ----- sv/dual_ema_pressure_detector.sv -----
// top level of the dual ema pressure detector
//
// input channel: one signed q1.15 sample per transfer (in_valid_i / in_stall_o).
// output channel: one result per sample (out_valid_o / out_stall_i) carrying
// fast and slow ema, their difference, the edge flags and rise/fall/sample counts.
// configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// ready is always high, unknown indexes are dropped. write only when idle.
//
// timing: a sample waits in the input register, the ema update, pressure
// compare and counter update run in one combinational pass, and the result
// lands in the output register. one sample per cycle while out_stall_i is
// low; the rate is set by the state feedback through the 17x25 multiply of
// each ema and the threshold compare.
//
// reset: both emas, the seed flag, edge history and all counters clear, the
// registers go back to their defaults. the first sample after reset seeds both
// averages. when the receiver stalls, the output register holds and the input
// register absorbs one more sample before in_stall_o rises.
module dual_ema_pressure_detector #(
  parameter int COUNT_BITS = dema_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic        [dema_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic        [dema_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // sample input
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [dema_pkg::SAMPLE_W-1:0] sample_i,
  // result output
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [dema_pkg::AVG_W-1:0]    fast_value_o,
  output logic signed [dema_pkg::AVG_W-1:0]    slow_value_o,
  output logic signed [dema_pkg::PRESS_W-1:0]  pressure_value_o,
  output logic                                 rise_event_o,
  output logic                                 fall_event_o,
  output logic        [dema_pkg::CNT_OUT_W-1:0] rise_count_o,
  output logic        [dema_pkg::CNT_OUT_W-1:0] fall_count_o,
  output logic        [dema_pkg::CNT_OUT_W-1:0] sample_count_o
);

  localparam int SHIFT_W = dema_pkg::AVG_W - dema_pkg::SAMPLE_W;

  dema_pkg::cfg_t   cfg;
  dema_pkg::flags_t flags;

  // input register
  logic                                 in_valid_q;
  logic signed [dema_pkg::SAMPLE_W-1:0] sample_q;

  // ema state
  logic                              seeded_q;
  logic signed [dema_pkg::AVG_W-1:0] fast_q, fast_d;
  logic signed [dema_pkg::AVG_W-1:0] slow_q, slow_d;
  logic signed [dema_pkg::AVG_W-1:0] fast_step, slow_step;
  logic signed [dema_pkg::AVG_W-1:0] x;
  logic signed [dema_pkg::PRESS_W-1:0] press;

  logic [COUNT_BITS-1:0] rise_cnt, fall_cnt, seen_cnt;

  // output register
  logic                                  out_valid_q;
  logic signed [dema_pkg::AVG_W-1:0]     fast_out_q;
  logic signed [dema_pkg::AVG_W-1:0]     slow_out_q;
  logic signed [dema_pkg::PRESS_W-1:0]   press_out_q;
  logic                                  rise_out_q;
  logic                                  fall_out_q;
  logic        [dema_pkg::CNT_OUT_W-1:0] rise_cnt_q;
  logic        [dema_pkg::CNT_OUT_W-1:0] fall_cnt_q;
  logic        [dema_pkg::CNT_OUT_W-1:0] seen_cnt_q;

  logic advance;  // output register free to take the held sample's result
  logic step;     // held sample is processed this cycle

  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  dema_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      sample_q <= sample_i;
    end
  end

  // q1.15 to q1.23
  assign x = {sample_q, {SHIFT_W{1'b0}}};

  dema_ema_step u_fast (
    .avg_i   (fast_q),
    .x_i     (x),
    .alpha_i (cfg.fast_alpha),
    .avg_o   (fast_step)
  );

  dema_ema_step u_slow (
    .avg_i   (slow_q),
    .x_i     (x),
    .alpha_i (cfg.slow_alpha),
    .avg_o   (slow_step)
  );

  // first sample after reset seeds both averages
  assign fast_d = seeded_q ? fast_step : x;
  assign slow_d = seeded_q ? slow_step : x;
  assign press  = dema_pkg::PRESS_W'(fast_d) - dema_pkg::PRESS_W'(slow_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q <= 1'b0;
      fast_q   <= '0;
      slow_q   <= '0;
    end else if (step) begin
      seeded_q <= 1'b1;
      fast_q   <= fast_d;
      slow_q   <= slow_d;
    end
  end

  dema_event #(
    .COUNT_BITS (COUNT_BITS)
  ) u_event (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .press_i    (press),
    .cfg_i      (cfg),
    .flags_o    (flags),
    .rise_cnt_o (rise_cnt),
    .fall_cnt_o (fall_cnt),
    .seen_cnt_o (seen_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      fast_out_q  <= fast_d;
      slow_out_q  <= slow_d;
      press_out_q <= press;
      rise_out_q  <= flags.rise;
      fall_out_q  <= flags.fall;
      // counts show their low bits, zero filled for narrow counters
      rise_cnt_q  <= dema_pkg::CNT_OUT_W'(rise_cnt);
      fall_cnt_q  <= dema_pkg::CNT_OUT_W'(fall_cnt);
      seen_cnt_q  <= dema_pkg::CNT_OUT_W'(seen_cnt);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign fast_value_o     = fast_out_q;
  assign slow_value_o     = slow_out_q;
  assign pressure_value_o = press_out_q;
  assign rise_event_o     = rise_out_q;
  assign fall_event_o     = fall_out_q;
  assign rise_count_o     = rise_cnt_q;
  assign fall_count_o     = fall_cnt_q;
  assign sample_count_o   = seen_cnt_q;

endmodule

// ----- sv/dema_checker.sv -----
// port level checks of the dual ema pressure detector, bound to the top level
module dema_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_stall_o,
  input  logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  input  logic signed [dema_pkg::AVG_W-1:0]      fast_value_o,
  input  logic signed [dema_pkg::AVG_W-1:0]      slow_value_o,
  input  logic signed [dema_pkg::PRESS_W-1:0]    pressure_value_o,
  input  logic                                   rise_event_o,
  input  logic                                   fall_event_o,
  input  logic        [dema_pkg::CNT_OUT_W-1:0]  sample_count_o
);

  // stalled result stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pressure_value_o) && $stable(sample_count_o))
    else $error("result changed while stalled");

  // input only backs up behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with output free");

  // pressure is fast minus slow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pressure_value_o ==
      dema_pkg::PRESS_W'(fast_value_o) - dema_pkg::PRESS_W'(slow_value_o))
    else $error("pressure does not match the two averages");

  // both edges cannot fire together and every result counts its sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(rise_event_o && fall_event_o) && (sample_count_o != '0))
    else $error("inconsistent event flags or sample count");

endmodule

bind dual_ema_pressure_detector dema_checker u_dema_checker (.*);
